// ----- design/bmg_pkg.sv -----
// Package for the Box-Muller Gaussian pair generator: payload types, stage counts,
// fixed-point constants and the per-stage arithmetic helpers.
// No dependencies; imported by bmg_pipe and box_muller_gaussian_pair.
package bmg_pkg;

  localparam int UNIFORM_BITS = 32;
  localparam int LOG_FB       = 26;
  localparam int TRIG_FB      = 30;
  localparam int LOG_STEPS    = 26;
  localparam int SQRT_STEPS   = 32;
  localparam int TRIG_TERMS   = 6;
  localparam int SIN_TERMS    = 5;
  localparam int TRIG_STAGES  = 3 * TRIG_TERMS;
  // The angle path is shorter than the radius path; its input is delayed so both meet.
  localparam int ANG_DELAY    = 41;
  localparam int LAST_STAGE   = 65;

  localparam logic [31:0] UMASK   = 32'((64'd1 << UNIFORM_BITS) - 64'd1);
  localparam logic [31:0] T_TOP   = 32'(64'(UNIFORM_BITS) << LOG_FB);
  localparam logic [31:0] LN2_Q32 = 32'd2977044471;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Reciprocals floor(2^32 / d) of the Taylor divisors; one correction step fixes the quotient.
  localparam logic [7:0]  SIN_DIV   [TRIG_TERMS] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
  localparam logic [31:0] SIN_RECIP [TRIG_TERMS] = '{32'd715827882, 32'd214748364,
      32'd102261126, 32'd59652323, 32'd39045157, 32'd27531841};
  localparam logic [7:0]  COS_DIV   [TRIG_TERMS] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
  localparam logic [31:0] COS_RECIP [TRIG_TERMS] = '{32'd2147483648, 32'd357913941,
      32'd143165576, 32'd76695844, 32'd47721858, 32'd32537631};

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  localparam logic REG_MEAN = 1'b0;
  localparam logic REG_STD  = 1'b1;

  typedef struct packed {
    logic [31:0] radius_uniform;
    logic [31:0] angle_uniform;
  } bmg_in_t;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               is_last;
  } bmg_out_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [29:0]        x2;
    logic [1:0]         quad;
    logic               sw;
    logic [30:0]        ts;
    logic [30:0]        tc;
    logic [30:0]        ps;
    logic [30:0]        pc;
    logic [30:0]        qs;
    logic [30:0]        qc;
    logic signed [32:0] ss;
    logic signed [32:0] sc;
  } trig_t;

  function automatic logic [4:0] lead_one(input logic [31:0] k);
    logic [4:0] e;
    e = '0;
    for (int i = 0; i < 32; i++) begin
      if (k[i]) e = 5'(i);
    end
    return e;
  endfunction

  // One squaring step of the log2 mantissa: returns {fraction bit, new mantissa}.
  function automatic logic [32:0] log_step(input logic [31:0] m);
    logic [63:0] sq;
    logic [32:0] h;
    sq = 64'(m) * 64'(m);
    h  = 33'(sq >> 31);
    if (h[32]) return {1'b1, h[32:1]};
    else return {1'b0, h[31:0]};
  endfunction

  function automatic sqrt_t sqrt_step(input sqrt_t s, input int i);
    sqrt_t o;
    logic [63:0] b;
    b = 64'd1 << (62 - 2 * i);
    if (s.rem >= s.root + b) begin
      o.rem  = s.rem - (s.root + b);
      o.root = (s.root >> 1) + b;
    end else begin
      o.rem  = s.rem;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  // Taylor term n, phase 0: multiply by x^2, phase 1: reciprocal multiply,
  // phase 2: quotient correction and accumulation.
  function automatic trig_t trig_step(input trig_t s, input int n, input int ph);
    trig_t o;
    logic [60:0] ms;
    logic [60:0] mc;
    logic [62:0] rs;
    logic [62:0] rc;
    logic [30:0] cs;
    logic [30:0] cc;
    o  = s;
    ms = 61'(s.ts) * 61'(s.x2);
    mc = 61'(s.tc) * 61'(s.x2);
    rs = 63'(s.ps) * 63'(SIN_RECIP[n]);
    rc = 63'(s.pc) * 63'(COS_RECIP[n]);
    cs = s.qs + 31'((s.ps - 31'(s.qs * 31'(SIN_DIV[n]))) >= 31'(SIN_DIV[n]));
    cc = s.qc + 31'((s.pc - 31'(s.qc * 31'(COS_DIV[n]))) >= 31'(COS_DIV[n]));
    case (ph)
      0: begin
        o.pc = 31'(mc >> TRIG_FB);
        if (n < SIN_TERMS) o.ps = 31'(ms >> TRIG_FB);
      end
      1: begin
        o.qc = 31'(rc >> 32);
        if (n < SIN_TERMS) o.qs = 31'(rs >> 32);
      end
      default: begin
        o.tc = cc;
        o.sc = (n % 2 == 0) ? s.sc - $signed({2'b00, cc}) : s.sc + $signed({2'b00, cc});
        if (n < SIN_TERMS) begin
          o.ts = cs;
          o.ss = (n % 2 == 0) ? s.ss - $signed({2'b00, cs}) : s.ss + $signed({2'b00, cs});
        end
      end
    endcase
    return o;
  endfunction

  function automatic logic [30:0] clamp_q30(input logic signed [32:0] v);
    if (v < 0) return '0;
    else if (v > $signed({2'b00, ONE_Q30})) return ONE_Q30;
    else return v[30:0];
  endfunction

  // z = r * trig, rounded half away from zero at the Q.30 point.
  function automatic logic signed [31:0] trig_mul(input logic signed [31:0] a,
                                                  input logic [31:0] r);
    logic [31:0] mag;
    logic [63:0] p;
    logic [31:0] q;
    mag = a[31] ? 32'(-a) : 32'(a);
    p   = 64'(mag) * 64'(r) + (64'd1 << (TRIG_FB - 1));
    q   = 32'(p >> TRIG_FB);
    return a[31] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [35:0] std_mul(input logic signed [31:0] z,
                                                 input logic [30:0] sd);
    logic [31:0] mag;
    logic [63:0] p;
    logic [35:0] m;
    mag = z[31] ? 32'(-z) : 32'(z);
    p   = 64'(mag) * 64'(sd) + (64'd1 << (LOG_FB - 1));
    m   = 36'(p >> LOG_FB);
    return z[31] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sd2147483647) return 32'sh7FFF_FFFF;
    else if (v < -37'sd2147483648) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

endpackage

// ----- design/box_muller_gaussian_pair.sv -----
// Top level of the Box-Muller Gaussian pair generator: configuration registers,
// result pair buffer and the datapath pipeline. Depends on bmg_pkg and bmg_pipe.
//
// Usage: each input transaction on in_valid/in_ready carries two uniform words,
// a nonzero radius fraction and an angle fraction of a full turn. For every
// input transaction the block sends two output transactions on
// out_valid/out_ready: r*cos(2*pi*u2) first and then r*sin(2*pi*u2) with
// is_last set, both scaled by std_dev, offset by mean_value and saturated to
// signed Q16.16. A radius word of zero is treated as the smallest fraction.
// The cosine result of an item is presented first, and its sine result
// follows once the cosine has been accepted. Input throughput is limited by
// the single result channel, which carries two results per item; the
// 66-stage pipeline itself takes a new item in any cycle
// it advances. The pipeline stalls as a whole when its last stage holds a
// pair that the output buffer cannot take, so a stalled receiver loses or repeats
// nothing. Reset (rst_n low at a clock edge) empties the pipeline and output
// buffer and sets mean_value to 0 and std_dev to 1.0. Configuration writes
// through cfg_we/cfg_index/cfg_wdata take effect at once and are meant for idle
// periods.
module box_muller_gaussian_pair import bmg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  bmg_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output bmg_out_t    out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic signed [31:0] mean_r;
  logic [30:0]        std_r;

  // Output buffer: holds one cosine/sine pair and walks through it.
  logic               buf_v_r, buf_v_nxt;
  logic               half_r, half_nxt;
  logic signed [31:0] cos_r;
  logic signed [31:0] sin_r;

  logic               pipe_valid;
  logic signed [31:0] pipe_cos;
  logic signed [31:0] pipe_sin;
  logic               take;
  logic               adv;
  logic               load;

  // The buffer is free when empty, or when its sine result leaves this cycle.
  assign take = !buf_v_r || (half_r && out_ready);
  assign adv  = !pipe_valid || take;
  assign load = pipe_valid && take;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
      std_r  <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MEAN: mean_r <= $signed(cfg_wdata);
        REG_STD:  std_r  <= cfg_wdata[30:0];
        default:  mean_r <= mean_r;
      endcase
    end
  end

  bmg_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .mean      (mean_r),
    .sd        (std_r),
    .out_valid (pipe_valid),
    .out_cos   (pipe_cos),
    .out_sin   (pipe_sin)
  );

  always_comb begin
    buf_v_nxt = buf_v_r;
    half_nxt  = half_r;
    if (load) begin
      buf_v_nxt = 1'b1;
      half_nxt  = 1'b0;
    end else if (buf_v_r && out_ready) begin
      if (half_r) buf_v_nxt = 1'b0;
      else half_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_v_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      buf_v_r <= buf_v_nxt;
      half_r  <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cos_r <= pipe_cos;
      sin_r <= pipe_sin;
    end
  end

  assign out_valid             = buf_v_r;
  assign out_data.sample_value = half_r ? sin_r : cos_r;
  assign out_data.is_last      = half_r;

  // A cosine transaction is always followed by the sine of the same pair.
  a_sine_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.is_last) |=> (out_valid && out_data.is_last))
    else $error("cosine result not followed by its sine result");

  // A pair always starts with its cosine result.
  a_pair_starts_cos: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !out_data.is_last)
    else $error("result pair did not start with the cosine");

  // An empty output buffer never holds back the input side.
  a_empty_buf_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !buf_v_r |-> in_ready)
    else $error("input stalled while the output buffer is empty");

  // A stalled pipeline keeps its finished pair until the buffer takes it.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_valid && !take) |=> (pipe_valid && $stable(pipe_cos) && $stable(pipe_sin)))
    else $error("finished pair changed while the pipeline was stalled");

endmodule

// ----- design/bmg_pipe.sv -----
// Datapath pipeline of the Box-Muller generator: log2, root, sine/cosine and scaling.
// Depends on bmg_pkg; all stages advance together on adv, with valid bits alongside.
module bmg_pipe import bmg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  bmg_in_t            in_data,
  input  logic signed [31:0] mean,
  input  logic [30:0]        sd,
  output logic               out_valid,
  output logic signed [31:0] out_cos,
  output logic signed [31:0] out_sin
);

  logic [LAST_STAGE:0] v_r;

  logic [31:0] k1_r;
  logic [31:0] a_r;
  logic [31:0] ad_r [1:ANG_DELAY];

  logic [4:0]  e_r  [0:LOG_STEPS];
  logic [31:0] m_r  [0:LOG_STEPS];
  logic [25:0] fr_r [0:LOG_STEPS];
  logic [31:0] t_r;
  logic [31:0] s_r;
  sqrt_t       sq_r [0:SQRT_STEPS-1];
  logic [31:0] r_r;

  logic [29:0] x_r;
  logic [1:0]  quad_r;
  logic        sw_r;
  trig_t       tr_r [0:TRIG_STAGES];
  logic signed [31:0] rc_r, rs_r;
  logic signed [31:0] zc_r, zs_r;
  logic signed [35:0] wc_r, ws_r;
  logic signed [31:0] oc_r, os_r;

  logic [31:0] k1_nxt;
  logic [31:0] a_nxt;
  logic [29:0] f_d;
  logic [29:0] g_d;
  logic [30:0] c0_d, s0_d, c_d, sn_d;
  logic signed [31:0] rc_nxt, rs_nxt;
  logic [63:0] x_prod;
  logic [32:0] ls_d [0:LOG_STEPS-1];

  assign k1_nxt = ((in_data.radius_uniform & UMASK) == '0) ? 32'd1
                                                           : (in_data.radius_uniform & UMASK);
  assign a_nxt  = 32'(in_data.angle_uniform << (32 - UNIFORM_BITS));

  // Fold the quarter turn about its midpoint so the series only sees [0, pi/4].
  assign f_d    = ad_r[ANG_DELAY][29:0];
  assign g_d    = f_d[29] ? 30'(ONE_Q30 - 31'(f_d)) : f_d;
  assign x_prod = 64'(g_d) * 64'(PI_Q30);

  always_comb begin
    for (int j = 0; j < LOG_STEPS; j++) ls_d[j] = log_step(m_r[j]);
  end

  always_comb begin
    c0_d = clamp_q30(tr_r[TRIG_STAGES].sc);
    s0_d = clamp_q30(tr_r[TRIG_STAGES].ss);
    c_d  = tr_r[TRIG_STAGES].sw ? s0_d : c0_d;
    sn_d = tr_r[TRIG_STAGES].sw ? c0_d : s0_d;
    case (tr_r[TRIG_STAGES].quad)
      QUAD_I: begin
        rc_nxt = $signed({1'b0, c_d});
        rs_nxt = $signed({1'b0, sn_d});
      end
      QUAD_II: begin
        rc_nxt = -$signed({1'b0, sn_d});
        rs_nxt = $signed({1'b0, c_d});
      end
      QUAD_III: begin
        rc_nxt = -$signed({1'b0, c_d});
        rs_nxt = -$signed({1'b0, sn_d});
      end
      default: begin
        rc_nxt = $signed({1'b0, sn_d});
        rs_nxt = -$signed({1'b0, c_d});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAST_STAGE-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1_r <= k1_nxt;
      a_r  <= a_nxt;
      ad_r[1] <= a_r;
      for (int i = 2; i <= ANG_DELAY; i++) ad_r[i] <= ad_r[i-1];

      // Radius: normalize, then one log2 fraction bit per stage.
      e_r[0]  <= lead_one(k1_r);
      m_r[0]  <= 32'(k1_r << (5'd31 - lead_one(k1_r)));
      fr_r[0] <= '0;
      for (int j = 0; j < LOG_STEPS; j++) begin
        e_r[j+1]  <= e_r[j];
        m_r[j+1]  <= ls_d[j][31:0];
        fr_r[j+1] <= {fr_r[j][24:0], ls_d[j][32]};
      end
      t_r <= T_TOP - 32'({e_r[LOG_STEPS], fr_r[LOG_STEPS]});
      s_r <= 32'((64'(t_r) * 64'(LN2_Q32) + (64'd1 << 30)) >> 31);

      sq_r[0] <= sqrt_step('{rem: 64'(s_r) << LOG_FB, root: 64'd0}, 0);
      for (int i = 1; i < SQRT_STEPS; i++) sq_r[i] <= sqrt_step(sq_r[i-1], i);
      r_r <= 32'(sq_r[SQRT_STEPS-1].root)
           + 32'(sq_r[SQRT_STEPS-1].rem > sq_r[SQRT_STEPS-1].root);

      // Angle: reduce to x, then three stages per Taylor term.
      x_r    <= 30'(x_prod >> 31);
      quad_r <= ad_r[ANG_DELAY][31:30];
      sw_r   <= f_d[29];
      tr_r[0] <= '{x2: 30'((64'(x_r) * 64'(x_r) + (64'd1 << 29)) >> TRIG_FB),
                   quad: quad_r, sw: sw_r,
                   ts: 31'(x_r), tc: ONE_Q30, ps: '0, pc: '0, qs: '0, qc: '0,
                   ss: $signed(33'(x_r)), sc: $signed({2'b00, ONE_Q30})};
      for (int k = 0; k < TRIG_STAGES; k++) tr_r[k+1] <= trig_step(tr_r[k], k / 3, k % 3);
      rc_r <= rc_nxt;
      rs_r <= rs_nxt;

      zc_r <= trig_mul(rc_r, r_r);
      zs_r <= trig_mul(rs_r, r_r);
      wc_r <= std_mul(zc_r, sd);
      ws_r <= std_mul(zs_r, sd);
      oc_r <= sat32(37'(mean) + 37'(wc_r));
      os_r <= sat32(37'(mean) + 37'(ws_r));
    end
  end

  assign out_valid = v_r[LAST_STAGE];
  assign out_cos   = oc_r;
  assign out_sin   = os_r;

endmodule

// ----- sim/box_muller_gaussian_pair_test.sv -----
// Self-checking testbench for the Box-Muller Gaussian pair generator.
// Depends on bmg_pkg and box_muller_gaussian_pair; an integer fixed-point
// predictor computes both samples of each pair and checks them in order.
`timescale 1ns / 1ps

module box_muller_gaussian_pair_test;
  import bmg_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  bmg_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  bmg_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_MEAN;
  logic [31:0] cfg_wdata = '0;

  box_muller_gaussian_pair dut (.*);

  always #5 clk = ~clk;

  // Uniform pairs waiting to be sent, and the samples they should produce.
  bmg_in_t  pending_pairs[$];
  bmg_out_t expected_samples[$];
  int       error_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  bit       stimulus_done = 1'b0;

  // Predictor's copy of the two registers.
  logic signed [63:0] model_mean = 0;
  logic [63:0]        model_std = 64'd65536;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Rounded product of a signed value by an unsigned one, half away from zero.
  function automatic logic signed [63:0] round_mul(input logic signed [63:0] a,
                                                   input logic [63:0] b, input int sh);
    logic [63:0] mag;
    mag = a[63] ? 64'(-a) : 64'(a);
    mag = (mag * b + (64'd1 << (sh - 1))) >> sh;
    return a[63] ? -$signed(mag) : $signed(mag);
  endfunction

  // -log2(k / 2^32) in Q.26, by repeated squaring of the normalized mantissa.
  function automatic logic [63:0] neg_log2(input logic [63:0] k);
    int          e;
    logic [63:0] m;
    logic [63:0] frac;
    e = 31;
    frac = 0;
    while (e > 0 && k[e] == 1'b0) e--;
    m = k << (31 - e);
    for (int i = 0; i < LOG_FB; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(UNIFORM_BITS) << LOG_FB) - ((64'(e) << LOG_FB) + frac);
  endfunction

  function automatic logic [63:0] root_nearest(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    if (v > res) res++;
    return res;
  endfunction

  // Taylor sine and cosine of g * pi / 2^31, both clamped to [0, 1.0] in Q.30.
  task automatic taylor_sin_cos(input logic [63:0] g, output logic signed [63:0] c,
                                output logic signed [63:0] s);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] acc;
    x = (g * 64'(PI_Q30)) >> 31;
    x2 = (x * x + (64'd1 << 29)) >> TRIG_FB;
    t = x;
    acc = $signed(x);
    for (int n = 1; n <= 5; n++) begin
      t = ((t * x2) >> TRIG_FB) / 64'((2 * n) * (2 * n + 1));
      acc = (n % 2) ? acc - $signed(t) : acc + $signed(t);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 <<< TRIG_FB)) acc = 64'sd1 <<< TRIG_FB;
    s = acc;
    t = 64'd1 << TRIG_FB;
    acc = $signed(t);
    for (int n = 1; n <= 6; n++) begin
      t = ((t * x2) >> TRIG_FB) / 64'((2 * n - 1) * (2 * n));
      acc = (n % 2) ? acc - $signed(t) : acc + $signed(t);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 <<< TRIG_FB)) acc = 64'sd1 <<< TRIG_FB;
    c = acc;
  endtask

  function automatic logic signed [31:0] scale_sample(input logic signed [63:0] r,
                                                      input logic signed [63:0] trig);
    logic signed [63:0] z;
    logic signed [63:0] v;
    z = round_mul(trig, 64'(r), TRIG_FB);
    v = model_mean + round_mul(z, model_std, LOG_FB);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Queues the cosine and sine samples that one uniform pair should produce.
  task automatic predict_gaussian_pair(input bmg_in_t item);
    logic [63:0]        k1;
    logic [63:0]        a;
    logic [63:0]        f;
    logic [63:0]        g;
    logic [63:0]        s;
    logic signed [63:0] r;
    logic signed [63:0] c0;
    logic signed [63:0] s0;
    logic signed [63:0] c;
    logic signed [63:0] sn;
    logic signed [63:0] rc;
    logic signed [63:0] rs;
    logic [1:0]         quad;
    k1 = 64'(item.radius_uniform & UMASK);
    if (k1 == 0) k1 = 1;  // A zero radius word counts as the smallest fraction.
    a = 64'(item.angle_uniform & UMASK) << (32 - UNIFORM_BITS);
    s = (neg_log2(k1) * 64'(LN2_Q32) + (64'd1 << 30)) >> 31;
    r = $signed(root_nearest(s << LOG_FB));
    quad = a[31:30];
    f = a & 64'h3FFF_FFFF;
    // The upper half of each quadrant uses the complement angle with swapped roles.
    g = (f >= (64'd1 << 29)) ? (64'd1 << 30) - f : f;
    taylor_sin_cos(g, c0, s0);
    if (f >= (64'd1 << 29)) begin
      c = s0;
      sn = c0;
    end else begin
      c = c0;
      sn = s0;
    end
    case (quad)
      QUAD_I: begin rc = c; rs = sn; end
      QUAD_II: begin rc = -sn; rs = c; end
      QUAD_III: begin rc = -c; rs = -sn; end
      default: begin rc = sn; rs = -c; end
    endcase
    expected_samples.push_back('{sample_value: scale_sample(r, rc), is_last: 1'b0});
    expected_samples.push_back('{sample_value: scale_sample(r, rs), is_last: 1'b1});
  endtask

  // Driver: one transaction at a time from the queue; valid holds until accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (in_valid) predict_gaussian_pair(in_data);
        if (pending_pairs.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_pairs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected sample %0d", out_data.sample_value));
        end else begin
          bmg_out_t exp_s;
          exp_s = expected_samples.pop_front();
          if (out_data.sample_value !== exp_s.sample_value)
            report_mismatch($sformatf("sample_value %0d, expected %0d",
                                      out_data.sample_value, exp_s.sample_value));
          if (out_data.is_last !== exp_s.is_last)
            report_mismatch($sformatf("is_last %0b, expected %0b",
                                      out_data.is_last, exp_s.is_last));
        end
      end
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  task automatic add_pair(input logic [31:0] k1, input logic [31:0] k2);
    pending_pairs.push_back('{radius_uniform: k1, angle_uniform: k2});
  endtask

  // Waits until the driver has sent everything and all samples are back.
  task automatic drain;
    while (pending_pairs.size() > 0 || in_valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Register writes happen only here, while the block is idle.
  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MEAN) model_mean = $signed({{32{val[31]}}, val});
    else model_std = 64'(val[30:0]);
  endtask

  task automatic random_pairs(input int count);
    logic [31:0] k1;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3, 0))
        0: k1 = $urandom_range(255, 0);                  // deep tail, includes zero
        1: k1 = 32'hFFFF_FFFF - $urandom_range(4095, 0); // radius near zero
        default: k1 = $urandom();
      endcase
      add_pair(k1, $urandom());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: radius extremes, zero radius, all quadrant edges and the
    // half-quadrant swap point.
    add_pair(32'd0, 32'd0);
    add_pair(32'd1, 32'h4000_0000);
    add_pair(32'hFFFF_FFFF, 32'h8000_0000);
    add_pair(32'h8000_0000, 32'hC000_0000);
    add_pair(32'd2, 32'h2000_0000);
    add_pair(32'd3, 32'h1FFF_FFFF);
    add_pair(32'h0000_FFFF, 32'h6000_0000);
    add_pair(32'h1234_5678, 32'hA000_0000);
    add_pair(32'h7FFF_FFFF, 32'hE000_0000);
    add_pair(32'h5555_5555, 32'hFFFF_FFFF);
    add_pair(32'hAAAA_AAAA, 32'h5555_5555);
    add_pair(32'd1, 32'h3FFF_FFFF);
    drain();

    // Saturation at both ends: huge deviation, then mean at each extreme.
    write_reg(REG_STD, 32'h7FFF_FFFF);
    write_reg(REG_MEAN, 32'h7FFF_0000);
    add_pair(32'd1, 32'd0);
    add_pair(32'd1, 32'h8000_0000);
    add_pair(32'd5, 32'h4000_0000);
    add_pair(32'hFFFF_FFFF, 32'h8000_0000);
    drain();
    write_reg(REG_MEAN, 32'h8000_0000);
    add_pair(32'd1, 32'd0);
    add_pair(32'd1, 32'h8000_0000);
    add_pair(32'h0000_0100, 32'h2000_0000);
    drain();

    // Random phases: receiver mostly idle, then sender mostly idle, then full speed.
    send_idle_pct = 31;
    recv_idle_pct = 78;
    write_reg(REG_STD, 32'd0);
    write_reg(REG_MEAN, 32'hFFFF_FFFF);
    random_pairs(100);
    drain();
    write_reg(REG_STD, 32'd65536);
    write_reg(REG_MEAN, 32'd0);
    random_pairs(300);
    drain();
    send_idle_pct = 78;
    recv_idle_pct = 31;
    write_reg(REG_STD, $urandom_range(32'h7FFF_FFFF, 0));
    write_reg(REG_MEAN, $urandom());
    random_pairs(350);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_STD, $urandom_range(32'h0010_0000, 0));
    write_reg(REG_MEAN, $urandom_range(32'h0100_0000, 0));
    random_pairs(370);
    drain();

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Worst case is roughly 1200 items; this timeout leaves a wide margin over that.
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/bmg_pkg.sv
design/bmg_pipe.sv
design/box_muller_gaussian_pair.sv
sim/box_muller_gaussian_pair_test.sv
